// ----- sv/kwm_pkg.sv -----
// Shared constants, types and codes for the k-way sorted merge block.
`timescale 1ns / 1ps
package kwm_pkg;

  localparam int NUM_LISTS   = 8;
  localparam int LIST_DEPTH  = 64;
  localparam int LIST_W      = $clog2(NUM_LISTS);
  localparam int PTR_W       = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int TREE_LVLS   = LIST_W;
  localparam int TREE_LEAVES = 1 << TREE_LVLS;
  localparam int SRCH_W      = (TREE_LVLS > 1) ? $clog2(TREE_LVLS) : 1;
  localparam int MEM_AW      = LIST_W + PTR_W;
  localparam int MEM_DEPTH   = NUM_LISTS << PTR_W;

  localparam int CMD_W = 2;
  localparam int IDX_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_DROP,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [LIST_W-1:0] list;
    logic [VAL_W-1:0]  value;
  } op_t;

  typedef struct packed {
    logic              vld;
    logic [LIST_W-1:0] idx;
    logic [VAL_W-1:0]  value;
  } node_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_REFILL
  } back_state_t;

endpackage

// ----- sv/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge: command queue front end and list back end.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  command, list_index, push_value
//   out      source     out_valid/out_stall  merged_value, source_list, status
//
// Push, clear and unused commands sustain one beat per cycle while the result register is free.
// Pop runs a search through the registered comparator tree, plus a refill step when the list
// head is refilled from the list memory; no new command is taken until the pop is done.
// Reset clears fill counts and pointers at once; the list memory needs no clearing.
// A two-entry queue decouples input stalls from the back end; the result register frees
// the back end as soon as the pending out beat is taken.
`timescale 1ns / 1ps
module k_way_sorted_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kwm_pkg::CMD_W-1:0]        command,
  input  logic [kwm_pkg::IDX_W-1:0]        list_index,
  input  logic signed [kwm_pkg::VAL_W-1:0] push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [kwm_pkg::VAL_W-1:0] merged_value,
  output logic [kwm_pkg::IDX_W-1:0]        source_list,
  output logic [kwm_pkg::ST_W-1:0]         status
);

  logic         q_valid;
  logic         q_take;
  kwm_pkg::op_t q_op;

  kwm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .list_index (list_index),
    .push_value (push_value),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_take     (q_take)
  );

  kwm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_take       (q_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merged_value (merged_value),
    .source_list  (source_list),
    .status       (status)
  );

endmodule

// ----- sv/kwm_front.sv -----
// Front end: accepts command beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module kwm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kwm_pkg::CMD_W-1:0]   command,
  input  logic [kwm_pkg::IDX_W-1:0]   list_index,
  input  logic signed [kwm_pkg::VAL_W-1:0] push_value,
  output logic                        q_valid,
  output kwm_pkg::op_t                q_op,
  input  logic                        q_take
);

  kwm_pkg::op_t slot [2];
  kwm_pkg::op_t op_in;
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         wr_en;

  always_comb begin
    op_in.list  = kwm_pkg::LIST_W'(list_index);
    op_in.value = push_value;
    case (kwm_pkg::cmd_t'(command))
      kwm_pkg::CMD_PUSH: begin
        op_in.kind = (int'(list_index) >= kwm_pkg::NUM_LISTS) ? kwm_pkg::OP_DROP
                                                              : kwm_pkg::OP_PUSH;
      end
      kwm_pkg::CMD_POP:   op_in.kind = kwm_pkg::OP_POP;
      kwm_pkg::CMD_CLEAR: op_in.kind = kwm_pkg::OP_CLEAR;
      default:            op_in.kind = kwm_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign wr_en    = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_op     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, q_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/kwm_min_tree.sv -----
// Registered comparator tree: finds the smallest valid list head, lowest index on ties.
`timescale 1ns / 1ps
module kwm_min_tree (
  input  logic           clk,
  input  kwm_pkg::node_t leaves [kwm_pkg::NUM_LISTS],
  output kwm_pkg::node_t root
);

  kwm_pkg::node_t leaf_d [kwm_pkg::TREE_LEAVES];
  kwm_pkg::node_t tree_q [kwm_pkg::TREE_LVLS][kwm_pkg::TREE_LEAVES/2];

  function automatic kwm_pkg::node_t pick(input kwm_pkg::node_t a, input kwm_pkg::node_t b);
    if (b.vld && (!a.vld || ($signed(b.value) < $signed(a.value)))) begin
      return b;
    end
    return a;
  endfunction

  always_comb begin
    for (int i = 0; i < kwm_pkg::TREE_LEAVES; i++) begin
      leaf_d[i] = '0;
      if (i < kwm_pkg::NUM_LISTS) begin
        leaf_d[i] = leaves[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < kwm_pkg::TREE_LEAVES / 2; j++) begin
      tree_q[0][j] <= pick(leaf_d[2*j], leaf_d[2*j+1]);
    end
    for (int l = 1; l < kwm_pkg::TREE_LVLS; l++) begin
      for (int j = 0; j < (kwm_pkg::TREE_LEAVES >> (l + 1)); j++) begin
        tree_q[l][j] <= pick(tree_q[l-1][2*j], tree_q[l-1][2*j+1]);
      end
    end
  end

  assign root = tree_q[kwm_pkg::TREE_LVLS-1][0];

endmodule

// ----- sv/kwm_back.sv -----
// Back end: list FIFOs in memory, head registers, pop search and the result register.
`timescale 1ns / 1ps
module kwm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  kwm_pkg::op_t                     q_op,
  output logic                             q_take,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [kwm_pkg::VAL_W-1:0] merged_value,
  output logic [kwm_pkg::IDX_W-1:0]        source_list,
  output logic [kwm_pkg::ST_W-1:0]         status
);

  localparam int LW = kwm_pkg::LIST_W;
  localparam int PW = kwm_pkg::PTR_W;
  localparam int CW = kwm_pkg::CNT_W;
  localparam int VW = kwm_pkg::VAL_W;

  kwm_pkg::back_state_t state, state_next;

  logic [CW-1:0] fill [kwm_pkg::NUM_LISTS];
  logic [PW-1:0] rdp  [kwm_pkg::NUM_LISTS];
  logic [PW-1:0] wrp  [kwm_pkg::NUM_LISTS];
  logic [VW-1:0] head [kwm_pkg::NUM_LISTS];
  logic [VW-1:0] mem  [kwm_pkg::MEM_DEPTH];
  logic [VW-1:0] rd_data;
  logic [LW-1:0] refill_list;
  logic [kwm_pkg::SRCH_W-1:0] cnt;

  kwm_pkg::node_t leaves [kwm_pkg::NUM_LISTS];
  kwm_pkg::node_t root;

  logic                   out_free;
  logic                   take_ok;
  logic                   search_done;
  logic                   refill_need;
  logic [LW-1:0]          op_list;
  logic [LW-1:0]          pop_list;

  logic                   mem_we;
  logic [kwm_pkg::MEM_AW-1:0] mem_waddr;
  logic                   mem_re;
  logic [kwm_pkg::MEM_AW-1:0] mem_raddr;
  logic                   start_search;
  logic                   upd_push;
  logic                   upd_pop;
  logic                   upd_clear;
  logic                   upd_refill;
  logic                   res_load;
  logic [VW-1:0]          res_value;
  logic [kwm_pkg::IDX_W-1:0] res_src;
  kwm_pkg::status_t       res_status;

  logic [VW-1:0]          out_value;
  logic [kwm_pkg::IDX_W-1:0] out_src;
  kwm_pkg::status_t       out_status;

  logic                   fill_over;
  logic                   any_nonempty;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(kwm_pkg::LIST_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
      leaves[i].vld   = (fill[i] != '0);
      leaves[i].idx   = LW'(i);
      leaves[i].value = head[i];
    end
  end

  kwm_min_tree u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  assign out_free    = !out_valid || !out_stall;
  assign take_ok     = (state == kwm_pkg::BK_IDLE) && q_valid && out_free;
  assign search_done = (cnt == kwm_pkg::SRCH_W'(kwm_pkg::TREE_LVLS - 1));
  assign op_list     = q_op.list;
  assign pop_list    = root.idx;
  assign refill_need = root.vld && (fill[pop_list] > CW'(1));

  always_comb begin
    state_next = state;
    case (state)
      kwm_pkg::BK_IDLE: begin
        if (take_ok && (q_op.kind == kwm_pkg::OP_POP)) begin
          state_next = kwm_pkg::BK_SEARCH;
        end
      end
      kwm_pkg::BK_SEARCH: begin
        if (search_done && out_free) begin
          state_next = refill_need ? kwm_pkg::BK_REFILL : kwm_pkg::BK_IDLE;
        end
      end
      kwm_pkg::BK_REFILL: state_next = kwm_pkg::BK_IDLE;
      default:            state_next = kwm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_take       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = {op_list, wrp[op_list]};
    mem_re       = 1'b0;
    mem_raddr    = {pop_list, ptr_inc(rdp[pop_list])};
    start_search = 1'b0;
    upd_push     = 1'b0;
    upd_pop      = 1'b0;
    upd_clear    = 1'b0;
    upd_refill   = 1'b0;
    res_load     = 1'b0;
    res_value    = '0;
    res_src      = '0;
    res_status   = kwm_pkg::ST_OK;
    case (state)
      kwm_pkg::BK_IDLE: begin
        if (take_ok) begin
          q_take = 1'b1;
          case (q_op.kind)
            kwm_pkg::OP_PUSH: begin
              res_load = 1'b1;
              if (fill[op_list] == CW'(kwm_pkg::LIST_DEPTH)) begin
                res_status = kwm_pkg::ST_DROPPED;
              end else begin
                mem_we   = 1'b1;
                upd_push = 1'b1;
              end
            end
            kwm_pkg::OP_POP: start_search = 1'b1;
            kwm_pkg::OP_CLEAR: begin
              upd_clear = 1'b1;
              res_load  = 1'b1;
            end
            kwm_pkg::OP_DROP: begin
              res_load   = 1'b1;
              res_status = kwm_pkg::ST_DROPPED;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      kwm_pkg::BK_SEARCH: begin
        if (search_done && out_free) begin
          res_load = 1'b1;
          if (root.vld) begin
            res_value = root.value;
            res_src   = kwm_pkg::IDX_W'(root.idx);
            upd_pop   = 1'b1;
            mem_re    = refill_need;
          end else begin
            res_status = kwm_pkg::ST_EMPTY;
          end
        end
      end
      kwm_pkg::BK_REFILL: upd_refill = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_op.value;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (upd_push && (fill[op_list] == '0)) begin
      head[op_list] <= q_op.value;
    end
    if (upd_refill) begin
      head[refill_list] <= rd_data;
    end
    if (upd_pop) begin
      refill_list <= pop_list;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::BK_IDLE;
      cnt   <= '0;
      for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
        fill[i] <= '0;
        rdp[i]  <= '0;
        wrp[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (start_search) begin
        cnt <= '0;
      end else if ((state == kwm_pkg::BK_SEARCH) && !search_done) begin
        cnt <= cnt + 1'b1;
      end
      if (upd_clear) begin
        for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
          fill[i] <= '0;
          rdp[i]  <= '0;
          wrp[i]  <= '0;
        end
      end
      if (upd_push) begin
        fill[op_list] <= fill[op_list] + 1'b1;
        wrp[op_list]  <= ptr_inc(wrp[op_list]);
      end
      if (upd_pop) begin
        fill[pop_list] <= fill[pop_list] - 1'b1;
        rdp[pop_list]  <= ptr_inc(rdp[pop_list]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value  <= res_value;
      out_src    <= res_src;
      out_status <= res_status;
    end
  end

  assign merged_value = out_value;
  assign source_list  = out_src;
  assign status       = out_status;

  always_comb begin
    fill_over    = 1'b0;
    any_nonempty = 1'b0;
    for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
      if (fill[i] > CW'(kwm_pkg::LIST_DEPTH)) begin
        fill_over = 1'b1;
      end
      if (fill[i] != '0) begin
        any_nonempty = 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) !fill_over)
    else $error("list fill count beyond depth");

  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken beat");

  a_empty_true: assert property (@(posedge clk) disable iff (rst)
    (res_load && (res_status == kwm_pkg::ST_EMPTY)) |-> !any_nonempty)
    else $error("empty reported while a list holds data");

  a_refill_seq: assert property (@(posedge clk) disable iff (rst)
    (state == kwm_pkg::BK_REFILL) |-> ($past(state) == kwm_pkg::BK_SEARCH))
    else $error("refill not preceded by search");

  a_refill_end: assert property (@(posedge clk) disable iff (rst)
    (state == kwm_pkg::BK_REFILL) |=> (state == kwm_pkg::BK_IDLE))
    else $error("refill did not return to idle");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the k-way sorted merge block with queue-based prediction.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT       = 800000;
  localparam int TARGET      = 1950;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 20;
  localparam longint VAL_MAX = 64'sd2147483647;

  typedef struct {
    bit                               drain;
    kwm_pkg::cmd_t                    cmd;
    logic [kwm_pkg::IDX_W-1:0]        idx;
    logic signed [kwm_pkg::VAL_W-1:0] val;
  } beat_t;

  typedef struct {
    logic signed [kwm_pkg::VAL_W-1:0] value;
    logic [kwm_pkg::IDX_W-1:0]        src;
    kwm_pkg::status_t                 st;
  } merge_res_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  kwm_pkg::cmd_t                    command = kwm_pkg::CMD_NONE;
  logic [kwm_pkg::IDX_W-1:0]        list_index = '0;
  logic signed [kwm_pkg::VAL_W-1:0] push_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [kwm_pkg::VAL_W-1:0] merged_value;
  logic [kwm_pkg::IDX_W-1:0]        source_list;
  logic [kwm_pkg::ST_W-1:0]         status;

  beat_t                            pend_beats[$];
  merge_res_t                       merge_exp[$];
  logic signed [kwm_pkg::VAL_W-1:0] list_vals[kwm_pkg::NUM_LISTS][$];
  longint                           cursor[kwm_pkg::NUM_LISTS];

  int cycles, errors, planned, beats_in, beats_out;
  int n_push, n_drop, n_pop, n_empty, n_clear;
  int in_gap, stall_left, hold_left;
  bit hold_done;
  wire quiet = ((cycles / 600) % 5) == 0;

  k_way_sorted_merge dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .list_index   (list_index),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merged_value (merged_value),
    .source_list  (source_list),
    .status       (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void predict_merge(input kwm_pkg::cmd_t cmd,
                                        input logic [kwm_pkg::IDX_W-1:0] idx,
                                        input logic signed [kwm_pkg::VAL_W-1:0] val);
    merge_res_t r;
    int best;
    r.value = '0;
    r.src   = '0;
    r.st    = kwm_pkg::ST_OK;
    best    = -1;
    case (cmd)
      kwm_pkg::CMD_PUSH: begin
        if (idx >= kwm_pkg::NUM_LISTS || list_vals[idx].size() >= kwm_pkg::LIST_DEPTH) begin
          r.st = kwm_pkg::ST_DROPPED;
          n_drop++;
        end else begin
          list_vals[idx].push_back(val);
          n_push++;
        end
      end
      kwm_pkg::CMD_POP: begin
        for (int i = 0; i < kwm_pkg::NUM_LISTS; i++)
          if (list_vals[i].size() != 0 && (best < 0 || list_vals[i][0] < list_vals[best][0]))
            best = i;
        if (best < 0) begin
          r.st = kwm_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.value = list_vals[best].pop_front();
          r.src   = best[kwm_pkg::IDX_W-1:0];
          n_pop++;
        end
      end
      kwm_pkg::CMD_CLEAR: begin
        foreach (list_vals[i]) list_vals[i].delete();
        n_clear++;
      end
      default: ;
    endcase
    merge_exp.push_back(r);
  endfunction

  task automatic add_beat(input kwm_pkg::cmd_t cmd, input int idx,
                          input logic signed [kwm_pkg::VAL_W-1:0] val);
    beat_t b;
    b.drain = 1'b0;
    b.cmd   = cmd;
    b.idx   = idx[kwm_pkg::IDX_W-1:0];
    b.val   = val;
    pend_beats.push_back(b);
    if (cmd != kwm_pkg::CMD_NONE) planned++;
  endtask

  task automatic add_drain();
    beat_t b;
    b.drain = 1'b1;
    b.cmd   = kwm_pkg::CMD_NONE;
    b.idx   = '0;
    b.val   = '0;
    pend_beats.push_back(b);
  endtask

  task automatic add_pops(input int n);
    for (int i = 0; i < n; i++) add_beat(kwm_pkg::CMD_POP, $urandom_range(0, 7), $urandom());
  endtask

  // append the next non-decreasing value of one list
  task automatic push_sorted(input int l);
    int r;
    longint step;
    r = $urandom_range(0, 9);
    if (r < 2) step = 0;
    else if (r < 8) step = $urandom_range(1, 1000);
    else step = longint'($urandom());
    cursor[l] = (cursor[l] + step > VAL_MAX) ? VAL_MAX : cursor[l] + step;
    add_beat(kwm_pkg::CMD_PUSH, l, cursor[l][kwm_pkg::VAL_W-1:0]);
  endtask

  task automatic reseed_cursors();
    foreach (cursor[i]) cursor[i] = longint'($signed($urandom()));
  endtask

  task automatic add_sorted_batch(input bit fresh);
    int n;
    int span;
    if (fresh) begin
      add_beat(kwm_pkg::CMD_CLEAR, $urandom_range(0, 7), $urandom());
      reseed_cursors();
    end
    n    = $urandom_range(4, 60);
    span = $urandom_range(1, kwm_pkg::NUM_LISTS);
    for (int i = 0; i < n; i++) begin
      push_sorted($urandom_range(0, span - 1));
      if ($urandom_range(0, 7) == 0) add_pops(1);
    end
    add_pops(n + $urandom_range(0, 2));
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++)
      add_beat(kwm_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom());
  endtask

  // driver: hold a stalled beat, otherwise advance through the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_merge(command, list_index, push_value);
        beats_in++;
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pend_beats.size() != 0 && pend_beats[0].drain) begin
        in_valid <= 1'b0;
        if (merge_exp.size() == 0) void'(pend_beats.pop_front());
      end else if (pend_beats.size() != 0) begin
        beat_t b;
        b = pend_beats.pop_front();
        in_valid   <= 1'b1;
        command    <= b.cmd;
        list_index <= b.idx;
        push_value <= b.val;
        in_gap     = quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure, with one long hold once traffic is flowing
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (!hold_done && beats_out >= 400) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      merge_res_t e;
      beats_out++;
      if (merge_exp.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (value %0d src %0d st %0d)",
                                  merged_value, source_list, status));
      end else begin
        e = merge_exp.pop_front();
        if (merged_value !== e.value)
          report_mismatch($sformatf("beat %0d merged_value %0d, want %0d",
                                    beats_out, merged_value, e.value));
        if (source_list !== e.src)
          report_mismatch($sformatf("beat %0d source_list %0d, want %0d",
                                    beats_out, source_list, e.src));
        if (status !== e.st)
          report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                    beats_out, status, e.st));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int r;
    int l;
    int m;
    // empty pop, unused command, extremes and ties across lists
    add_beat(kwm_pkg::CMD_POP, 0, 0);
    add_beat(kwm_pkg::CMD_NONE, 5, 32'h1234_5678);
    add_beat(kwm_pkg::CMD_PUSH, 0, 32'sh8000_0000);
    add_beat(kwm_pkg::CMD_PUSH, 0, -32'sd1);
    add_beat(kwm_pkg::CMD_PUSH, 1, 32'sh7FFF_FFFF);
    add_beat(kwm_pkg::CMD_PUSH, 2, -32'sd1);
    add_beat(kwm_pkg::CMD_PUSH, 7, 32'sd0);
    add_beat(kwm_pkg::CMD_PUSH, 3, 32'sh8000_0000);
    add_pops(7);
    add_beat(kwm_pkg::CMD_PUSH, 5, 32'sd5);
    add_beat(kwm_pkg::CMD_PUSH, 6, 32'shAAAA_AAAA);
    add_beat(kwm_pkg::CMD_CLEAR, 0, 0);
    add_beat(kwm_pkg::CMD_POP, 3, 32'hFFFF_FFFF);
    add_beat(kwm_pkg::CMD_PUSH, 6, 32'shAAAA_AAAA);
    add_beat(kwm_pkg::CMD_PUSH, 6, 32'sh5555_5555);
    add_beat(kwm_pkg::CMD_NONE, 7, 32'hFFFF_FFFF);
    add_pops(3);
    add_drain();

    // fill two lists to the brim, overflow them, then drain them out
    add_beat(kwm_pkg::CMD_CLEAR, 0, 0);
    reseed_cursors();
    l = $urandom_range(0, 7);
    m = (l + $urandom_range(1, 7)) % kwm_pkg::NUM_LISTS;
    for (int i = 0; i <= kwm_pkg::LIST_DEPTH; i++) begin
      push_sorted(l);
      push_sorted(m);
    end
    add_pops(2 * kwm_pkg::LIST_DEPTH + 1);

    while (planned < TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) add_sorted_batch($urandom_range(0, 3) == 0);
      else if (r < 90) add_noise();
      else begin
        add_drain();
        add_pops($urandom_range(1, 4));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pend_beats.size() != 0 || in_valid || merge_exp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d input beats: %0d pushes, %0d drops, %0d pops,",
             beats_in, n_push, n_drop, n_pop);
    $display("%0d empty pops, %0d clears; %0d result beats checked in %0d cycles, %0d mismatches",
             n_empty, n_clear, beats_out, cycles, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
